// ----- rtl/core/xrng_pkg.sv -----
// ----------------------------------------------------------------------------
// xrng_pkg
// Shared types, constants and helpers of the xoshiro128 range generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrng_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NUM_SEEDS  = 4;
  localparam int unsigned SEED_IDX_W = $clog2(NUM_SEEDS);
  localparam int unsigned DIV_STEPS  = WORD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned ROT_SS     = 7;
  localparam int unsigned ROT_ADV    = 11;
  localparam int unsigned SHL_ADV    = 9;
  localparam int unsigned FRAC_SHIFT = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REQ_W-1:0]  req_t;

  localparam req_t REQ_STAR    = 3'd0;
  localparam req_t REQ_PLUS    = 3'd1;
  localparam req_t REQ_UNIFORM = 3'd2;
  localparam req_t REQ_FRAC    = 3'd3;
  localparam req_t REQ_RESEED  = 3'd4;

  localparam logic DIV_SEL_SCALE = 1'b0;
  localparam logic DIV_SEL_PICK  = 1'b1;

  typedef enum logic [1:0] {
    SEL_WORD,
    SEL_FRAC,
    SEL_QUO,
    SEL_ZERO
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     div_sel;
    logic     div_step;
    logic     save_scale;
    logic     ss_a;
    logic     ss_b;
    logic     plus;
    logic     reseed;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic range_zero;
    logic reject;
    logic div_last;
  } dp_sts_t;

  function automatic word_t rotl32(input word_t x, input int unsigned k);
    rotl32 = (x << k) | (x >> (WORD_W - k));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xrng_if.sv -----
// ----------------------------------------------------------------------------
// xrng_req_if / xrng_res_if
// Valid/ready channels carrying requests and results of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface xrng_req_if;
  logic                        valid;
  logic                        ready;
  logic [xrng_pkg::REQ_W-1:0]  req_type;
  logic [xrng_pkg::WORD_W-1:0] range_low;
  logic [xrng_pkg::WORD_W-1:0] range_high;

  modport source (output valid, output req_type, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input req_type, input range_low, input range_high,
                  output ready);
endinterface

interface xrng_res_if;
  logic                        valid;
  logic                        ready;
  logic [xrng_pkg::WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xrng_ctrl.sv -----
// ----------------------------------------------------------------------------
// xrng_ctrl
// Request sequencer: steps draws, rejection loop, divisions and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire xrng_pkg::req_t   in_req_type,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire xrng_pkg::dp_sts_t sts,
  output xrng_pkg::dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_DIV_SCALE,
    S_SAVE,
    S_SS_A,
    S_SS_B,
    S_CHECK,
    S_DIV_PICK,
    S_PLUS,
    S_FIN
  } state_t;

  state_t         state_r, state_nxt;
  xrng_pkg::req_t req_r, req_nxt;
  logic           full_r, full_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    full_nxt      = full_r;
    cmd           = '0;
    cmd.out_sel   = xrng_pkg::SEL_ZERO;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          req_nxt     = in_req_type;
          full_nxt    = 1'b0;
          case (in_req_type)
            xrng_pkg::REQ_STAR:    state_nxt = S_SS_A;
            xrng_pkg::REQ_PLUS:    state_nxt = S_PLUS;
            xrng_pkg::REQ_FRAC:    state_nxt = S_PLUS;
            xrng_pkg::REQ_UNIFORM: state_nxt = S_RANGE;
            default:               state_nxt = S_FIN;
          endcase
        end
      end
      S_RANGE: begin
        if (sts.range_zero) begin
          full_nxt  = 1'b1;
          state_nxt = S_SS_A;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = xrng_pkg::DIV_SEL_SCALE;
          state_nxt     = S_DIV_SCALE;
        end
      end
      S_DIV_SCALE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd.save_scale = 1'b1;
        state_nxt      = S_SS_A;
      end
      S_SS_A: begin
        cmd.ss_a  = 1'b1;
        state_nxt = S_SS_B;
      end
      S_SS_B: begin
        cmd.ss_b  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r == xrng_pkg::REQ_UNIFORM && !full_r) begin
          if (sts.reject) begin
            state_nxt = S_SS_A;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = xrng_pkg::DIV_SEL_PICK;
            state_nxt     = S_DIV_PICK;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV_PICK: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_PLUS: begin
        cmd.plus  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        case (req_r)
          xrng_pkg::REQ_STAR:    cmd.out_sel = xrng_pkg::SEL_WORD;
          xrng_pkg::REQ_PLUS:    cmd.out_sel = xrng_pkg::SEL_WORD;
          xrng_pkg::REQ_FRAC:    cmd.out_sel = xrng_pkg::SEL_FRAC;
          xrng_pkg::REQ_UNIFORM: cmd.out_sel = full_r ? xrng_pkg::SEL_WORD
                                                      : xrng_pkg::SEL_QUO;
          default:               cmd.out_sel = xrng_pkg::SEL_ZERO;
        endcase
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.reseed    = (req_r == xrng_pkg::REQ_RESEED);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= xrng_pkg::REQ_STAR;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/xrng_dp.sv -----
// ----------------------------------------------------------------------------
// xrng_dp
// Datapath: seed registers, generator state, word shaping, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire xrng_pkg::word_t              in_range_low,
  input  wire xrng_pkg::word_t              in_range_high,
  input  wire                               cfg_we,
  input  wire [xrng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire xrng_pkg::word_t              cfg_data,
  input  wire xrng_pkg::dp_cmd_t            cmd,
  output xrng_pkg::dp_sts_t                 sts,
  output xrng_pkg::word_t                   out_value
);

  xrng_pkg::word_t seed_r [xrng_pkg::NUM_SEEDS];
  xrng_pkg::word_t s_r    [4];
  xrng_pkg::word_t adv    [4];
  xrng_pkg::word_t m_r, w_r, range_r, lo_r, scale_r, limit_r;
  xrng_pkg::word_t dvd_r, rem_r, dvs_r, out_value_r;
  logic [xrng_pkg::DIV_CNT_W-1:0] cnt_r;
  xrng_pkg::word_t m_rot, rem_nxt, sel_value;
  logic [xrng_pkg::WORD_W:0] partial, diff;

  // one xoshiro128 step
  always_comb begin
    adv[2] = s_r[2] ^ s_r[0];
    adv[3] = s_r[3] ^ s_r[1];
    adv[1] = s_r[1] ^ adv[2];
    adv[0] = s_r[0] ^ adv[3];
    adv[2] = adv[2] ^ (s_r[1] << xrng_pkg::SHL_ADV);
    adv[3] = xrng_pkg::rotl32(adv[3], xrng_pkg::ROT_ADV);
  end

  assign m_rot   = xrng_pkg::rotl32(m_r, xrng_pkg::ROT_SS);
  assign partial = {rem_r, dvd_r[xrng_pkg::WORD_W-1]};
  assign diff    = partial - {1'b0, dvs_r};
  assign rem_nxt = diff[xrng_pkg::WORD_W] ? partial[xrng_pkg::WORD_W-1:0]
                                          : diff[xrng_pkg::WORD_W-1:0];

  assign sts.range_zero = (range_r == '0);
  assign sts.reject     = (w_r >= limit_r);
  assign sts.div_last   = (cnt_r == xrng_pkg::DIV_CNT_W'(xrng_pkg::DIV_STEPS - 1));

  always_comb begin
    case (cmd.out_sel)
      xrng_pkg::SEL_WORD: sel_value = w_r;
      xrng_pkg::SEL_FRAC: sel_value = w_r >> xrng_pkg::FRAC_SHIFT;
      xrng_pkg::SEL_QUO:  sel_value = dvd_r + lo_r;
      default:            sel_value = '0;
    endcase
  end

  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r[0] <= xrng_pkg::WORD_W'(1);
      seed_r[1] <= '0;
      seed_r[2] <= '0;
      seed_r[3] <= '0;
      s_r[0]    <= xrng_pkg::WORD_W'(1);
      s_r[1]    <= '0;
      s_r[2]    <= '0;
      s_r[3]    <= '0;
    end else begin
      if (cfg_we && cfg_index < xrng_pkg::CFG_IDX_W'(xrng_pkg::NUM_SEEDS)) begin
        seed_r[cfg_index[xrng_pkg::SEED_IDX_W-1:0]] <= cfg_data;
      end
      if (cmd.ss_a || cmd.plus) begin
        s_r <= adv;
      end else if (cmd.reseed) begin
        s_r <= seed_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      range_r <= in_range_high - in_range_low + xrng_pkg::WORD_W'(1);
      lo_r    <= in_range_low;
    end
    if (cmd.ss_a) begin
      m_r <= (s_r[1] << 2) + s_r[1];
    end
    if (cmd.ss_b) begin
      w_r <= (m_rot << 3) + m_rot;
    end else if (cmd.plus) begin
      w_r <= s_r[0] + s_r[3];
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= '0;
      if (cmd.div_sel == xrng_pkg::DIV_SEL_PICK) begin
        dvd_r <= w_r;
        dvs_r <= scale_r;
      end else begin
        dvd_r <= '1;
        dvs_r <= range_r;
      end
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[xrng_pkg::WORD_W-2:0], ~diff[xrng_pkg::WORD_W]};
      cnt_r <= cnt_r + xrng_pkg::DIV_CNT_W'(1);
    end
    if (cmd.save_scale) begin
      scale_r <= dvd_r;
      limit_r <= ~rem_r;
    end
    if (cmd.out_load) begin
      out_value_r <= sel_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/xoshiro128_generator_with_range_core.sv -----
// ----------------------------------------------------------------------------
// xoshiro128_generator_with_range_core
// xoshiro128 star-star / plus generator with uniform range and fraction.
// ----------------------------------------------------------------------------
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | req_type[2:0], range_low[31:0], range_high[31:0]
// out_ch   | out | valid/ready        | value[31:0]
// cfg_*    | in  | cfg_we (no wait)   | cfg_index[2:0], cfg_data[31:0]
//
// Star-star draws through S_SS_A and S_SS_B; plus and fraction through S_PLUS;
// reseed and unused codes go straight to S_FIN. Uniform redraws each rejected
// word and runs two serial divisions (scale, then word / scale); a full range skips both.
// One request at a time; in_ch.ready is high only when the sequencer is idle.
// A stalled result holds in the output register; the next request may be
// accepted meanwhile and waits for it to drain. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro128_generator_with_range_core (
  input  wire                            clk,
  input  wire                            rst_n,
  xrng_req_if.sink                       in_ch,
  xrng_res_if.source                     out_ch,
  input  wire                            cfg_we,
  input  wire [xrng_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [xrng_pkg::WORD_W-1:0]     cfg_data
);

  xrng_pkg::dp_cmd_t cmd;
  xrng_pkg::dp_sts_t sts;

  xrng_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  xrng_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_range_low  (in_ch.range_low),
    .in_range_high (in_ch.range_high),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_value     (out_ch.value)
  );

endmodule

`default_nettype wire

// ----- rtl/core/xrng_checker.sv -----
// ----------------------------------------------------------------------------
// xrng_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xrng_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire [xrng_pkg::REQ_W-1:0]   in_req_type,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [xrng_pkg::WORD_W-1:0]  out_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result transaction changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("ports not idle after reset");

  a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_req_type == xrng_pkg::REQ_RESEED
      |-> ##2 out_valid && out_value == '0)
    else $error("reseed transaction did not return zero");

endmodule

bind xoshiro128_generator_with_range_core xrng_checker u_xrng_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.value)
);

`default_nettype wire

// ----- tb/xoshiro128_generator_with_range_core_tb.sv -----
// ----------------------------------------------------------------------------
// xoshiro128_generator_with_range_core_tb
// Self-checking bench for the xoshiro128 range generator. A directed table
// covers reset values, range extremes, wrapped and reversed bounds, unused
// request codes and an all-zero seed. Random requests follow over several
// seed settings. A local generator predicts every result, and random stalls
// are applied on both channels.
// ----------------------------------------------------------------------------
module xoshiro128_generator_with_range_core_tb;
  import xrng_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SEED_SETS   = 8;
  localparam int unsigned SET_ITEMS   = 153;
  localparam int unsigned ZERO_SPLIT  = 17;
  localparam int unsigned PLAN_LEN    = 24;

  localparam req_t REQ_SPARE5 = 3'd5;
  localparam req_t REQ_SPARE6 = 3'd6;
  localparam req_t REQ_SPARE7 = 3'd7;

  typedef struct packed {
    req_t  rq;
    word_t lo;
    word_t hi;
    logic  known;
    word_t value;
  } probe_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  xrng_req_if req_ch ();
  xrng_res_if res_ch ();

  xoshiro128_generator_with_range_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  word_t gen_s [NUM_SEEDS];
  word_t seed_r [NUM_SEEDS];
  word_t pending_values [$];
  word_t due_value;
  int    fail_count;
  int    quiet_cycles;
  bit    calm;

  probe_t plan [PLAN_LEN] = '{
    '{REQ_STAR,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_PLUS,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{REQ_FRAC,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h1234_5678, 32'h1234_5678, 1'b1, 32'h1234_5678},
    '{REQ_UNIFORM, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'hFFFF_FFF0, 32'h0000_000F, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_SPARE5,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_SPARE6,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{REQ_SPARE7,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 32'h0000_0000},
    '{REQ_RESEED,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_STAR,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_PLUS,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{REQ_RESEED,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_STAR,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_PLUS,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_FRAC,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_UNIFORM, 32'h0000_0005, 32'h0000_0009, 1'b1, 32'h0000_0005},
    '{REQ_UNIFORM, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{REQ_UNIFORM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}
  };

  always #5 clk = ~clk;

  function automatic word_t spin_left(word_t x, int unsigned k);
    logic [2*WORD_W-1:0] twice;
    twice = {x, x} >> (WORD_W - k);
    return twice[WORD_W-1:0];
  endfunction

  function automatic void step_state();
    word_t t;
    t = gen_s[1] << 9;
    gen_s[2] ^= gen_s[0];
    gen_s[3] ^= gen_s[1];
    gen_s[1] ^= gen_s[2];
    gen_s[0] ^= gen_s[3];
    gen_s[2] ^= t;
    gen_s[3] = spin_left(gen_s[3], 11);
  endfunction

  function automatic word_t star_word();
    word_t w;
    w = spin_left(gen_s[1] * 5, 7) * 9;
    step_state();
    return w;
  endfunction

  function automatic word_t plus_word();
    word_t w;
    w = gen_s[0] + gen_s[3];
    step_state();
    return w;
  endfunction

  function automatic word_t uniform_pick(word_t lo, word_t hi);
    word_t span;
    word_t scale;
    word_t ceiling;
    word_t w;
    span = hi - lo + 1;
    if (span == 0) begin
      return star_word();
    end
    scale = 32'hFFFF_FFFF / span;
    ceiling = span * scale;
    do begin
      w = star_word();
    end while (w >= ceiling);
    return w / scale + lo;
  endfunction

  function automatic word_t predict_value(req_t rq, word_t lo, word_t hi);
    case (rq)
      REQ_STAR:    return star_word();
      REQ_PLUS:    return plus_word();
      REQ_UNIFORM: return uniform_pick(lo, hi);
      REQ_FRAC:    return plus_word() >> 8;
      REQ_RESEED: begin
        for (int i = 0; i < NUM_SEEDS; i++) gen_s[i] = seed_r[i];
        return '0;
      end
      default:     return '0;
    endcase
  endfunction

  task automatic send_item(req_t rq, word_t lo, word_t hi, logic known, word_t fixed);
    word_t v;
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rq;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
    v = predict_value(rq, lo, hi);
    pending_values.push_back(known ? fixed : v);
  endtask

  task automatic hold_sender(int unsigned n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  task automatic load_seeds(word_t w0, word_t w1, word_t w2, word_t w3);
    word_t words [NUM_SEEDS];
    logic [CFG_IDX_W-1:0] stray;
    words = '{w0, w1, w2, w3};
    wait_drained();
    repeat (2) @(posedge clk);
    // writes beyond the last seed register must be dropped
    stray = CFG_IDX_W'(NUM_SEEDS + $urandom_range(0, 3));
    cfg_we    <= 1'b1;
    cfg_index <= stray;
    cfg_data  <= $urandom;
    @(posedge clk);
    for (int i = 0; i < NUM_SEEDS; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= words[i];
      @(posedge clk);
      seed_r[i] = words[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(logic first);
    req_t  rq;
    word_t lo;
    word_t hi;
    int    r;
    lo = $urandom;
    hi = $urandom;
    r  = $urandom_range(0, 99);
    if (first || r < 4) rq = REQ_RESEED;
    else if (r < 8) begin
      case ($urandom_range(0, 2))
        0:       rq = REQ_SPARE5;
        1:       rq = REQ_SPARE6;
        default: rq = REQ_SPARE7;
      endcase
    end
    else if (r < 24) rq = REQ_STAR;
    else if (r < 36) rq = REQ_PLUS;
    else if (r < 48) rq = REQ_FRAC;
    else begin
      rq = REQ_UNIFORM;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: hi = lo + $urandom_range(0, 300);
        4, 5:       ;
        6:          hi = lo - 1;
        7: begin
          lo = '0;
          hi = 32'hFFFF_FFFF >> $urandom_range(0, 31);
        end
        8:          hi = lo + 32'h8000_0000 + $urandom_range(0, 3);
        default:    hi = lo;
      endcase
    end
    send_item(rq, lo, hi, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_values.size() == 0) begin
        fail_count++;
        $error("value: expected none, actual %h", res_ch.value);
      end else begin
        due_value = pending_values.pop_front();
        if (res_ch.value !== due_value) begin
          fail_count++;
          $error("value: expected %h, actual %h", due_value, res_ch.value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    clk = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_STAR;
    req_ch.range_low  <= '0;
    req_ch.range_high <= '0;
    gen_s  = '{32'd1, 32'd0, 32'd0, 32'd0};
    seed_r = '{32'd1, 32'd0, 32'd0, 32'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < ZERO_SPLIT; i++) begin
      send_item(plan[i].rq, plan[i].lo, plan[i].hi, plan[i].known, plan[i].value);
    end
    load_seeds('0, '0, '0, '0);
    for (int i = ZERO_SPLIT; i < PLAN_LEN; i++) begin
      if ($urandom_range(0, 2) == 0) hold_sender($urandom_range(1, 9));
      send_item(plan[i].rq, plan[i].lo, plan[i].hi, plan[i].known, plan[i].value);
    end

    for (int p = 0; p < SEED_SETS; p++) begin
      case (p)
        0:       load_seeds('1, '1, '1, '1);
        1:       load_seeds('0, '0, '0, '0);
        2:       load_seeds(32'd1, '0, '0, '0);
        3:       load_seeds('0, '0, '0, 32'h8000_0000);
        default: load_seeds($urandom, $urandom, $urandom, $urandom);
      endcase
      if (p == SEED_SETS - 1) calm = 1'b1;
      for (int k = 0; k < SET_ITEMS; k++) begin
        if (p == 4 && k == SET_ITEMS / 2) wait_drained();
        if (!calm && $urandom_range(0, 2 + p % 3) == 0) hold_sender($urandom_range(1, 9));
        send_random(k == 0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
